[hw/rtl/dbc_pkg.sv]
// Shared types, constants and digit/segment functions for the button counter.
`default_nettype none
package dbc_pkg;

  localparam int unsigned HISTORY_DEPTH = 12;
  localparam int unsigned BTN_W         = 8;
  localparam int unsigned CNT_W         = 10;
  localparam int unsigned SEG_W         = 8;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 10'd1023;
  localparam logic [CNT_W-1:0] COUNT_WRAP  = 10'd1;
  localparam logic [SEG_W-1:0] ZERO_CODE   = 8'hc0;
  localparam logic [SEG_W-1:0] BLANK_CODE  = 8'hff;

  // register index as decoded from paddr[2]
  localparam logic REG_DISPLAY_BASE = 1'b0;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } base_t;

  // payload handed from the state stage to the segment stage
  typedef struct packed {
    logic [CNT_W-1:0] disp_count;
    base_t            disp_base;
    logic [CNT_W-1:0] count;
    logic [BTN_W-1:0] mask;
  } stage_t;

  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] d);
    logic [SEG_W-1:0] c;
    case (d)
      4'h0:    c = 8'hc0;
      4'h1:    c = 8'hf9;
      4'h2:    c = 8'ha4;
      4'h3:    c = 8'hb0;
      4'h4:    c = 8'h99;
      4'h5:    c = 8'h92;
      4'h6:    c = 8'h82;
      4'h7:    c = 8'hf8;
      4'h8:    c = 8'h80;
      4'h9:    c = 8'h98;
      4'ha:    c = 8'h88;
      4'hb:    c = 8'h83;
      4'hc:    c = 8'hc6;
      4'hd:    c = 8'ha1;
      4'he:    c = 8'h86;
      4'hf:    c = 8'h8e;
      default: c = BLANK_CODE;
    endcase
    return c;
  endfunction

  // Decimal split of a 10-bit value by reciprocal multiplies:
  // r*41>>12 is r/100 for r < 1000, q*205>>11 is q/10 for q < 100.
  function automatic logic [15:0] dec_digits(input logic [CNT_W-1:0] v);
    logic             th;
    logic [CNT_W-1:0] r;
    logic [15:0]      ph;
    logic [3:0]       h;
    logic [6:0]       q;
    logic [14:0]      pt;
    logic [3:0]       t;
    logic [3:0]       u;
    th = (v >= 10'd1000);
    r  = th ? (v - 10'd1000) : v;
    ph = {6'd0, r} * 16'd41;
    h  = ph[15:12];
    q  = 7'(r - 10'({6'd0, h} * 10'd100));
    pt = {8'd0, q} * 15'd205;
    t  = pt[14:11];
    u  = 4'(q - 7'({3'd0, t} * 7'd10));
    return {3'd0, th, h, t, u};
  endfunction

  function automatic logic [15:0] split_digits(input logic [CNT_W-1:0] v, input base_t b);
    logic [15:0] d;
    case (b)
      BASE_DEC: d = dec_digits(v);
      BASE_HEX: d = {2'd0, v};
      BASE_OCT: d = {3'd0, v[9], 1'b0, v[8:6], 1'b0, v[5:3], 1'b0, v[2:0]};
      BASE_BIN: d = {3'd0, v[3], 3'd0, v[2], 3'd0, v[1], 3'd0, v[0]};
      default:  d = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/dbc_seg_stage.sv]
// Result register stage: digit split, segment encoding and blanking.
`default_nettype none
module dbc_seg_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire dbc_pkg::stage_t               stage_in,
  output logic                               stage_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit0,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit1,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_colon,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit2,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit3,
  output logic [dbc_pkg::CNT_W-1:0]          out_press_count,
  output logic [dbc_pkg::BTN_W-1:0]          out_debounced_mask
);
  import dbc_pkg::*;

  logic              out_valid_r;
  logic [15:0]       dig;
  logic              blank3, blank2, blank1;
  logic [SEG_W-1:0]  d0_r, d1_r, d2_r, d3_r;
  logic [SEG_W-1:0]  d0_nxt, d1_nxt, d2_nxt, d3_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [BTN_W-1:0]  mask_r;

  assign stage_ready = !out_valid_r || out_ready;

  always_comb begin
    dig    = split_digits(stage_in.disp_count, stage_in.disp_base);
    // leading zeros go dark from the top down; units always lit
    blank3 = (dig[15:12] == 4'd0);
    blank2 = blank3 && (dig[11:8] == 4'd0);
    blank1 = blank2 && (dig[7:4] == 4'd0);
    d0_nxt = seg_encode(dig[3:0]);
    d1_nxt = blank1 ? BLANK_CODE : seg_encode(dig[7:4]);
    d2_nxt = blank2 ? BLANK_CODE : seg_encode(dig[11:8]);
    d3_nxt = blank3 ? BLANK_CODE : seg_encode(dig[15:12]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d0_r   <= d0_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      d3_r   <= d3_nxt;
      cnt_r  <= stage_in.count;
      mask_r <= stage_in.mask;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seg_digit0     = d0_r;
  assign out_seg_digit1     = d1_r;
  assign out_seg_colon      = BLANK_CODE;
  assign out_seg_digit2     = d2_r;
  assign out_seg_digit3     = d3_r;
  assign out_press_count    = cnt_r;
  assign out_debounced_mask = mask_r;

endmodule
`default_nettype wire

[hw/rtl/debounced_button_counter_7seg.sv]
// An accepted request goes through the state stage and then the result register stage.
// Throughput: one request per cycle while out_ready holds; the debounce AND and count
// update sit in the state stage, digit split and segment encode in the result register stage.
// Reset (rst_n low, synchronous): history, count and press flag clear, base is decimal,
// the display count is zero (the segment registers are not reset); no result pending.
`default_nettype none
module debounced_button_counter_7seg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dbc_pkg::BTN_W-1:0]     in_raw_buttons,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit0,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit1,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_colon,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit2,
  output logic [dbc_pkg::SEG_W-1:0]          out_seg_digit3,
  output logic [dbc_pkg::CNT_W-1:0]          out_press_count,
  output logic [dbc_pkg::BTN_W-1:0]          out_debounced_mask,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dbc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [dbc_pkg::PDATA_W-1:0]   pwdata,
  output logic [dbc_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import dbc_pkg::*;

  logic              s1_valid_r;
  logic              stage_ready;
  logic              acc;
  logic              adv;
  logic [BTN_W-1:0]  hist_r [HISTORY_DEPTH-1];
  logic [BTN_W-1:0]  sample;
  logic [BTN_W-1:0]  mask_nxt;
  logic [BTN_W-1:0]  mask_r;
  logic              rel_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W:0]    sum;
  logic              press;
  logic [CNT_W-1:0]  disp_cnt_r;
  base_t             disp_base_r;
  base_t             base_r;
  stage_t            stage;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_DEC;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DISPLAY_BASE)) begin
      base_r <= base_t'(pwdata[1:0]);
    end
  end

  assign prdata = (paddr[2] == REG_DISPLAY_BASE) ? {30'd0, base_r} : '0;

  // handshake: the state stage moves on whenever the result register can take it
  assign in_ready = !s1_valid_r || stage_ready;
  assign acc      = in_valid && in_ready;
  assign adv      = s1_valid_r && stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // debounce: new sample ANDed with the previous depth-1 samples
  always_comb begin
    sample   = ~in_raw_buttons;
    mask_nxt = sample;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      mask_nxt = mask_nxt & hist_r[i];
    end
    press   = (mask_nxt != '0) && !rel_r;
    sum     = {1'b0, cnt_r} + {{(CNT_W+1-BTN_W){1'b0}}, mask_nxt};
    cnt_nxt = (sum > {1'b0, COUNT_LIMIT}) ? COUNT_WRAP : sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= '0;
      end
      rel_r       <= 1'b0;
      cnt_r       <= '0;
      disp_cnt_r  <= '0;
      disp_base_r <= BASE_DEC;
    end else if (acc) begin
      hist_r[0] <= sample;
      for (int i = 1; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      rel_r <= (mask_nxt != '0);
      if (press) begin
        cnt_r       <= cnt_nxt;
        disp_cnt_r  <= cnt_nxt;
        disp_base_r <= base_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mask_r <= mask_nxt;
    end
  end

  assign stage.disp_count = disp_cnt_r;
  assign stage.disp_base  = disp_base_r;
  assign stage.count      = cnt_r;
  assign stage.mask       = mask_r;

  dbc_seg_stage u_seg (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (adv),
    .stage_in           (stage),
    .stage_ready        (stage_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_seg_digit0     (out_seg_digit0),
    .out_seg_digit1     (out_seg_digit1),
    .out_seg_colon      (out_seg_colon),
    .out_seg_digit2     (out_seg_digit2),
    .out_seg_digit3     (out_seg_digit3),
    .out_press_count    (out_press_count),
    .out_debounced_mask (out_debounced_mask)
  );

`ifndef SYNTHESIS
  // units digit is never blanked
  a_units_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seg_digit0 != BLANK_CODE))
    else $error("units digit blanked");

  // blanking runs from the top down
  a_blank_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_seg_digit2 == BLANK_CODE)) |-> (out_seg_digit3 == BLANK_CODE))
    else $error("digit2 blank while digit3 lit");

  // a held press leaves the count alone
  a_held_press: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && rel_r && (mask_nxt != '0)) |=> $stable(cnt_r))
    else $error("count moved during held press");

  // a press edge arms the release flag
  a_press_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && press) |=> rel_r)
    else $error("release flag not set after press");
`endif

endmodule
`default_nettype wire
